// File: rtl/pso_pkg.sv
// Shared types, constants and codes for the particle swarm update block.
package pso_pkg;

  // Default number of dimension slots in each element memory.
  localparam int unsigned MAX_DIMS_DEF = 64;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Field widths.
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned DIMS_W = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned LGAIN_W = 20;

  // Stream payload widths.
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 64;

  // Register reset values.
  localparam logic [GAIN_W-1:0] C1_RESET   = 16'd8397;
  localparam logic [GAIN_W-1:0] C2_RESET   = 16'd8397;
  localparam logic [GAIN_W-1:0] K_RESET    = 16'd47828;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 7'd8;

  // Personal best score after reset is the largest positive value.
  localparam logic signed [VAL_W-1:0] SCORE_RESET = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN     = 32'sh8000_0000;

  // Register indexes on the configuration port (byte address is 4 * index).
  typedef enum logic [1:0] {
    REG_COGNITIVE    = 2'd0,
    REG_SOCIAL       = 2'd1,
    REG_CONSTRICTION = 2'd2,
    REG_DIMS         = 2'd3
  } reg_idx_t;

  // Current register values as seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0] c1;
    logic [GAIN_W-1:0] c2;
    logic [GAIN_W-1:0] k;
    logic [DIMS_W-1:0] dims;
  } cfg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIFF,
    ST_PROD,
    ST_SUM,
    ST_SCALE,
    ST_WRITE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic diff;
    logic prod;
    logic sum;
    logic scale;
    logic write;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/pso_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pso_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pso_cfg.sv
// APB-style register file holding the gains, constriction factor and dimension count.
module pso_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pso_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pso_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pso_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output pso_pkg::cfg_t                    cfg
);
  import pso_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes, each value masked to its width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c1   <= C1_RESET;
      cfg.c2   <= C2_RESET;
      cfg.k    <= K_RESET;
      cfg.dims <= DIMS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COGNITIVE:    cfg.c1   <= pwdata[GAIN_W-1:0];
        REG_SOCIAL:       cfg.c2   <= pwdata[GAIN_W-1:0];
        REG_CONSTRICTION: cfg.k    <= pwdata[GAIN_W-1:0];
        REG_DIMS:         cfg.dims <= pwdata[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_COGNITIVE:    prdata = CFG_DATA_W'(cfg.c1);
      REG_SOCIAL:       prdata = CFG_DATA_W'(cfg.c2);
      REG_CONSTRICTION: prdata = CFG_DATA_W'(cfg.k);
      REG_DIMS:         prdata = CFG_DATA_W'(cfg.dims);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/pso_ctrl.sv
// Controller state machine sequencing the clear sweep and each element update.
module pso_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  pso_pkg::dp_status_t status,
  output pso_pkg::dp_cmd_t    cmd
);
  import pso_pkg::*;

  state_t state;
  state_t state_next;

  // State register; the memories are swept to zero right after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        // Hold until the output register can take the result.
        cmd.write = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pso_dp.sv
// Datapath: element memories, latched gains, velocity and position arithmetic, output register.
module pso_dp #(
  parameter int unsigned MAX_DIMS = pso_pkg::MAX_DIMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pso_pkg::cfg_t                     cfg,
  input  pso_pkg::dp_cmd_t                  cmd,
  output pso_pkg::dp_status_t               status,
  input  logic [pso_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pso_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast
);
  import pso_pkg::*;

  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned CW = ($clog2(MAX_DIMS + 1) > DIMS_W) ? $clog2(MAX_DIMS + 1)
                                                                 : DIMS_W;

  // Input fields.
  logic signed [VAL_W-1:0]  in_score;
  logic        [FRAC_W-1:0] in_r1;
  logic        [FRAC_W-1:0] in_r2;
  logic signed [VAL_W-1:0]  in_gbest;

  assign in_score = s_tdata[31:0];
  assign in_r1    = s_tdata[47:32];
  assign in_r2    = s_tdata[63:48];
  assign in_gbest = s_tdata[95:64];

  // Per-update state.
  logic [AW-1:0]            dim_counter;
  logic signed [VAL_W-1:0]  best_score;
  logic                     improved;
  logic [LGAIN_W-1:0]       r1_gain;
  logic [LGAIN_W-1:0]       r2_gain;

  // Per-element pipeline registers.
  logic [AW-1:0]            idx;
  logic                     last;
  logic signed [VAL_W-1:0]  gbest;
  logic signed [VAL_W-1:0]  pos_q;
  logic signed [VAL_W-1:0]  vel_q;
  logic signed [32:0]       d1_q;
  logic signed [32:0]       d2_q;
  logic signed [37:0]       t1_q;
  logic signed [37:0]       t2_q;
  logic signed [39:0]       sum_q;
  logic signed [VAL_W-1:0]  vnew_q;
  logic [AW-1:0]            clr_addr;

  // Memory ports.
  logic [VAL_W-1:0]         pos_rd;
  logic [VAL_W-1:0]         vel_rd;
  logic [VAL_W-1:0]         pb_rd;
  logic                     pv_we;
  logic                     pb_we;
  logic [AW-1:0]            waddr;
  logic [VAL_W-1:0]         pos_wd;
  logic [VAL_W-1:0]         vel_wd;
  logic [VAL_W-1:0]         pb_wd;

  // Dimension index with the count clamped to one through MAX_DIMS.
  logic [CW-1:0]            dims_ext;
  logic [CW-1:0]            count;
  logic [CW-1:0]            last_idx;
  logic                     is_last;
  logic [AW-1:0]            idx_now;
  logic                     first;

  assign dims_ext = CW'(cfg.dims);
  assign count    = (dims_ext == '0) ? CW'(1)
                  : ((dims_ext > CW'(MAX_DIMS)) ? CW'(MAX_DIMS) : dims_ext);
  assign last_idx = count - CW'(1);
  assign is_last  = CW'(dim_counter) >= last_idx;
  assign idx_now  = is_last ? last_idx[AW-1:0] : dim_counter;
  assign first    = (dim_counter == '0);

  // Latched gains c*r in unsigned Q4.16.
  logic [31:0] g1_prod;
  logic [31:0] g2_prod;

  assign g1_prod = 32'(cfg.c1) * 32'(in_r1);
  assign g2_prod = 32'(cfg.c2) * 32'(in_r2);

  // Request intake: index, score check and gain latch on the first element.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_counter <= '0;
      best_score  <= SCORE_RESET;
      improved    <= 1'b0;
      r1_gain     <= '0;
      r2_gain     <= '0;
    end else if (cmd.accept) begin
      dim_counter <= is_last ? '0 : dim_counter + AW'(1);
      if (first) begin
        if (in_score < best_score) begin
          best_score <= in_score;
          improved   <= 1'b1;
        end else begin
          improved   <= 1'b0;
        end
        r1_gain <= g1_prod[31:12];
        r2_gain <= g2_prod[31:12];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx   <= idx_now;
      last  <= is_last;
      gbest <= in_gbest;
    end
  end

  // Differences; an improved personal best equals the position, so its term is zero.
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      pos_q <= pos_rd;
      vel_q <= vel_rd;
      d1_q  <= improved ? '0
             : $signed({pb_rd[31], pb_rd}) - $signed({pos_rd[31], pos_rd});
      d2_q  <= $signed({gbest[31], gbest}) - $signed({pos_rd[31], pos_rd});
    end
  end

  // Gain times difference, floored back to Q16.16.
  logic signed [53:0] p1_full;
  logic signed [53:0] p2_full;

  assign p1_full = 54'($signed({1'b0, r1_gain})) * 54'(d1_q);
  assign p2_full = 54'($signed({1'b0, r2_gain})) * 54'(d2_q);

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      t1_q <= p1_full[53:16];
      t2_q <= p2_full[53:16];
    end
  end

  // Exact three-term sum.
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_q <= $signed({{8{vel_q[31]}}, vel_q})
             + $signed({{2{t1_q[37]}}, t1_q})
             + $signed({{2{t2_q[37]}}, t2_q});
    end
  end

  // Constriction scaling with floor and saturation.
  logic signed [56:0] k_prod;
  logic signed [40:0] scaled;
  logic signed [VAL_W-1:0] vnew_sat;

  assign k_prod = 57'($signed({1'b0, cfg.k})) * 57'(sum_q);
  assign scaled = k_prod[56:16];

  always_comb begin
    if (!scaled[40] && (scaled[39:31] != '0)) begin
      vnew_sat = VAL_MAX;
    end else if (scaled[40] && (scaled[39:31] != '1)) begin
      vnew_sat = VAL_MIN;
    end else begin
      vnew_sat = scaled[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      vnew_q <= vnew_sat;
    end
  end

  // New position with saturation.
  logic signed [32:0]      pos_sum;
  logic signed [VAL_W-1:0] pnew;

  assign pos_sum = $signed({pos_q[31], pos_q}) + $signed({vnew_q[31], vnew_q});

  always_comb begin
    if (pos_sum[32] != pos_sum[31]) begin
      pnew = pos_sum[32] ? VAL_MIN : VAL_MAX;
    end else begin
      pnew = pos_sum[31:0];
    end
  end

  // Output register: a finished result waits here while the next element starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.write) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      m_tdata <= {vnew_q, pnew};
      m_tlast <= last;
    end
  end

  // Clear sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign status.clear_last = (clr_addr == AW'(MAX_DIMS - 1));
  assign status.out_free   = !m_tvalid || m_tready;

  // Memory write controls: zeros during the sweep, results during write-back.
  assign pv_we  = cmd.clear || cmd.write;
  assign pb_we  = cmd.clear || (cmd.write && improved);
  assign waddr  = cmd.clear ? clr_addr : idx;
  assign pos_wd = cmd.clear ? '0 : pnew;
  assign vel_wd = cmd.clear ? '0 : vnew_q;
  assign pb_wd  = cmd.clear ? '0 : pos_q;

  pso_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_DIMS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (waddr),
    .wdata (pos_wd),
    .raddr (idx_now),
    .rdata (pos_rd)
  );

  pso_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_DIMS)
  ) u_vel_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (waddr),
    .wdata (vel_wd),
    .raddr (idx_now),
    .rdata (vel_rd)
  );

  pso_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_DIMS)
  ) u_pb_ram (
    .clk   (clk),
    .we    (pb_we),
    .waddr (waddr),
    .wdata (pb_wd),
    .raddr (idx_now),
    .rdata (pb_rd)
  );

endmodule

// File: rtl/pso_particle_update_top.sv
// Top level of the particle swarm update block with constriction factor.
//
//   Channel  Direction  Handshake           Payload
//   s_*      in         s_tvalid/s_tready   s_tdata: score, r1, r2, swarm best value
//   m_*      out        m_tvalid/m_tready   m_tdata: new position, new velocity; m_tlast
//   p*       in         psel/penable/pready gains, constriction, dimension count
//
// Each element goes through intake with the memory read, differences, gain products, sum,
// constriction product with saturation, and write-back into the output register; the next
// element is taken only after write-back. The two chained multiplies sit in separate steps.
// After reset a clearing pass zeroes the three element memories, one entry a cycle,
// through all MAX_DIMS entries; no request is taken then, register writes are.
// A result waiting in the output register stalls only the write-back step.
module pso_particle_update_top #(
  parameter int unsigned MAX_DIMS = pso_pkg::MAX_DIMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Bits 31:0 fitness_score, 47:32 rand_personal, 63:48 rand_global,
  // 95:64 swarm_best_value.
  input  logic [pso_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Bits 31:0 new_position, 63:32 new_velocity.
  output logic [pso_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pso_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pso_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pso_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pso_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers.
  pso_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  pso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  pso_dp #(
    .MAX_DIMS (MAX_DIMS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: bench/pso_particle_update_top_tb.sv
// Self-checking bench for the particle swarm update block: stream stimulus, APB setup, predictor.
module pso_particle_update_top_tb;
  import pso_pkg::*;

  localparam int unsigned DIM_SLOTS    = MAX_DIMS_DEF;
  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned ITEM_TARGET  = 1650;
  localparam int unsigned DRAIN_CYCLES = 24;

  // One dimension request as it sits on s_tdata, fitness score in the lowest bits.
  typedef struct packed {
    logic [VAL_W-1:0]  swarm_best;
    logic [FRAC_W-1:0] r_global;
    logic [FRAC_W-1:0] r_personal;
    logic [VAL_W-1:0]  fitness;
  } dim_request_t;

  // Predicted outcome of one dimension.
  typedef struct {
    logic signed [VAL_W-1:0] position;
    logic signed [VAL_W-1:0] velocity;
    logic                    last;
  } dim_update_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  m_tlast;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Register copies used by the predictor.
  logic [GAIN_W-1:0] c1_gain  = C1_RESET;
  logic [GAIN_W-1:0] c2_gain  = C2_RESET;
  logic [GAIN_W-1:0] k_factor = K_RESET;
  logic [DIMS_W-1:0] dims_cfg = DIMS_RESET;

  // Particle state mirrored by the predictor.
  logic signed [VAL_W-1:0] position_mem [DIM_SLOTS];
  logic signed [VAL_W-1:0] velocity_mem [DIM_SLOTS];
  logic signed [VAL_W-1:0] pbest_mem    [DIM_SLOTS];
  logic signed [VAL_W-1:0] best_score = SCORE_RESET;
  int unsigned             dim_index  = 0;
  bit                      improving  = 1'b0;
  longint                  r1_gain    = 0;
  longint                  r2_gain    = 0;

  dim_request_t pending_requests [$];
  dim_update_t  expected_updates [$];

  int unsigned             error_count  = 0;
  int unsigned             idle_cycles  = 0;
  int unsigned             queued_total = 0;
  bit                      steady       = 1'b0;
  logic signed [VAL_W-1:0] score_floor  = SCORE_RESET;

  pso_particle_update_top #(.MAX_DIMS(DIM_SLOTS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Saturate a wide value to signed Q16.16.
  function automatic logic signed [VAL_W-1:0] clamp32(input longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  // Advance the mirrored particle by one dimension and return its new position and velocity.
  function automatic dim_update_t update_dimension(input dim_request_t req);
    int unsigned             count;
    int unsigned             idx;
    longint                  pos;
    longint                  d1;
    longint                  d2;
    longint                  acc;
    logic signed [VAL_W-1:0] vnew;
    dim_update_t             res;
    count = 32'(dims_cfg);
    if (count < 1) count = 1;
    if (count > DIM_SLOTS) count = DIM_SLOTS;
    idx = dim_index;
    // A count lowered mid-update ends the update on the next element.
    if (idx >= count) idx = count - 1;
    res.last = (idx == count - 1);
    // The first element latches the score check and both random gains.
    if (dim_index == 0) begin
      if ($signed(req.fitness) < best_score) begin
        best_score = req.fitness;
        improving  = 1'b1;
      end else begin
        improving = 1'b0;
      end
      r1_gain = (longint'(c1_gain) * longint'(req.r_personal)) >>> 12;
      r2_gain = (longint'(c2_gain) * longint'(req.r_global)) >>> 12;
    end
    pos = longint'(position_mem[idx]);
    if (improving) pbest_mem[idx] = position_mem[idx];
    d1  = longint'(pbest_mem[idx]) - pos;
    d2  = longint'($signed(req.swarm_best)) - pos;
    acc = longint'(velocity_mem[idx]) + ((r1_gain * d1) >>> 16) + ((r2_gain * d2) >>> 16);
    vnew = clamp32((longint'(k_factor) * acc) >>> 16);
    res.velocity = vnew;
    res.position = clamp32(pos + longint'(vnew));
    velocity_mem[idx] = res.velocity;
    position_mem[idx] = res.position;
    dim_index = res.last ? 0 : idx + 1;
    return res;
  endfunction

  // Request driver: predicts on every accepted request, then presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_updates.push_back(update_dimension(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          s_tdata  <= pending_requests.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin : monitor
    dim_update_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_updates.size() == 0) begin
          $error("unexpected result: new_position %0d new_velocity %0d",
                 $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
          error_count++;
        end else begin
          want = expected_updates.pop_front();
          if (m_tdata[31:0] !== want.position) begin
            $error("new_position: expected %0d, actual %0d", want.position,
                   $signed(m_tdata[31:0]));
            error_count++;
          end
          if (m_tdata[63:32] !== want.velocity) begin
            $error("new_velocity: expected %0d, actual %0d", want.velocity,
                   $signed(m_tdata[63:32]));
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $error("final_dim: expected %0d, actual %0d", want.last, m_tlast);
            error_count++;
          end
        end
      end
      m_tready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** pso_particle_update_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One APB write; bits above the register width carry random junk.
  task automatic write_register(input reg_idx_t idx, input logic [GAIN_W-1:0] value);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = $urandom();
    if (idx == REG_DIMS) wdata[DIMS_W-1:0] = value[DIMS_W-1:0];
    else wdata[GAIN_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_COGNITIVE:    c1_gain  = wdata[GAIN_W-1:0];
      REG_SOCIAL:       c2_gain  = wdata[GAIN_W-1:0];
      REG_CONSTRICTION: k_factor = wdata[GAIN_W-1:0];
      REG_DIMS:         dims_cfg = wdata[DIMS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [GAIN_W-1:0] c1, input logic [GAIN_W-1:0] c2,
                           input logic [GAIN_W-1:0] k, input logic [DIMS_W-1:0] dims);
    write_register(REG_COGNITIVE, c1);
    write_register(REG_SOCIAL, c2);
    write_register(REG_CONSTRICTION, k);
    write_register(REG_DIMS, {9'd0, dims});
  endtask

  task automatic push_request(input logic [VAL_W-1:0] fitness, input logic [FRAC_W-1:0] r1,
                              input logic [FRAC_W-1:0] r2, input logic [VAL_W-1:0] gbest);
    dim_request_t req;
    req.fitness    = fitness;
    req.r_personal = r1;
    req.r_global   = r2;
    req.swarm_best = gbest;
    pending_requests.push_back(req);
    queued_total++;
    if ($signed(fitness) < score_floor) score_floor = fitness;
  endtask

  // Random requests; scores often sit just under or at the lowest seen so far, or are VAL_MIN if lowest_score.
  task automatic queue_requests(input int unsigned count, input bit lowest_score);
    logic [VAL_W-1:0]  fitness;
    logic [FRAC_W-1:0] r1;
    logic [FRAC_W-1:0] r2;
    logic [VAL_W-1:0]  gbest;
    int unsigned       pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (lowest_score) fitness = VAL_MIN;
      else if (pick < 45 && score_floor > VAL_MIN + 1000)
        fitness = score_floor - $urandom_range(1000, 1);
      else if (pick < 65) fitness = score_floor;
      else fitness = $urandom();
      pick = $urandom_range(99);
      r1 = (pick < 10) ? '0 : (pick < 20) ? '1 : FRAC_W'($urandom());
      pick = $urandom_range(99);
      r2 = (pick < 10) ? '0 : (pick < 20) ? '1 : FRAC_W'($urandom());
      pick = $urandom_range(99);
      if (pick < 3) gbest = VAL_MAX;
      else if (pick < 6) gbest = VAL_MIN;
      else if (pick < 40) gbest = 32'(int'($urandom_range(2097151)) - 1048576);
      else if (pick < 70) gbest = 32'(int'($urandom_range(536870911)) - 268435456);
      else gbest = $urandom();
      push_request(fitness, r1, r2, gbest);
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || expected_updates.size() != 0);
  endtask

  // Stimulus sequence: directed corners, fixed extreme settings, then random phases.
  initial begin : stimulus
    logic [VAL_W-1:0]  corner_values [8];
    logic [VAL_W-1:0]  upd_score [3];
    logic [FRAC_W-1:0] upd_r1 [3];
    logic [FRAC_W-1:0] upd_r2 [3];
    int unsigned       pick;
    logic [GAIN_W-1:0] c1;
    logic [GAIN_W-1:0] c2;
    logic [GAIN_W-1:0] k;
    logic [DIMS_W-1:0] dims;
    corner_values = '{VAL_MAX, VAL_MIN, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000,
                      VAL_MAX, VAL_MIN};
    // A tie with the reset score, a real improvement, then a tie with that.
    upd_score = '{SCORE_RESET, 32'd0, 32'd0};
    upd_r1    = '{16'hFFFF, 16'h0000, 16'h8000};
    upd_r2    = '{16'hFFFF, 16'h0000, 16'hFFFF};
    foreach (position_mem[j]) begin
      position_mem[j] = '0;
      velocity_mem[j] = '0;
      pbest_mem[j]    = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed updates at the reset settings of eight dimensions.
    for (int u = 0; u < 3; u++) begin
      for (int d = 0; d < 8; d++) begin
        push_request(upd_score[u], upd_r1[u], upd_r2[u],
                     corner_values[(u == 2) ? 7 - d : d]);
      end
    end
    wait_for_drain();

    // Largest gains and the full dimension count; ends mid-update.
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd64);
    queue_requests(150, 1'b0);
    wait_for_drain();

    // Zero gains and a zero count, which acts as a single dimension.
    configure(16'h0000, 16'h0000, 16'h0000, 7'd0);
    queue_requests(20, 1'b0);
    wait_for_drain();

    // A count above the memory depth, run with no idling on either side.
    steady = 1'b1;
    configure(C1_RESET, C2_RESET, K_RESET, 7'd127);
    queue_requests(300, 1'b0);
    wait_for_drain();
    steady = 1'b0;

    // Random settings; phase lengths are random and need not be multiples of the count.
    while (queued_total < ITEM_TARGET - 40) begin
      pick = $urandom_range(99);
      if (pick < 70) dims = DIMS_W'($urandom_range(8, 1));
      else if (pick < 90) dims = DIMS_W'($urandom_range(64, 9));
      else dims = DIMS_W'($urandom_range(127));
      c1 = ($urandom_range(99) < 70) ? GAIN_W'($urandom_range(12288, 4096))
                                     : GAIN_W'($urandom());
      c2 = ($urandom_range(99) < 70) ? GAIN_W'($urandom_range(12288, 4096))
                                     : GAIN_W'($urandom());
      k  = ($urandom_range(99) < 70) ? GAIN_W'($urandom_range(65535, 32768))
                                     : GAIN_W'($urandom());
      configure(c1, c2, k, dims);
      queue_requests($urandom_range(140, 40), 1'b0);
      wait_for_drain();
    end

    // Most negative score last, since nothing can improve on it.
    configure(GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()), 7'd3);
    queue_requests(40, 1'b1);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_updates.size() == 0) begin
      $display("** pso_particle_update_top: PASSED **");
    end else begin
      $display("** pso_particle_update_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: pso_particle_update_top.f
rtl/pso_pkg.sv
rtl/pso_ram.sv
rtl/pso_cfg.sv
rtl/pso_ctrl.sv
rtl/pso_dp.sv
rtl/pso_particle_update_top.sv
bench/pso_particle_update_top_tb.sv
